[src/cblc_pkg.sv]
// ----------------------------------------------------------------------------
// cblc_pkg
// Shared types, constants and helpers of the chunked body length checker.
// ----------------------------------------------------------------------------
package cblc_pkg;

	localparam int COUNT_BITS = 32;
	localparam int TOTAL_W    = 32;
	localparam int CHUNK_W    = 32;
	localparam int REM_W      = CHUNK_W + 2;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 8;

	localparam logic [TOTAL_W:0] TOTAL_CAP = (COUNT_BITS >= TOTAL_W) ?
		{1'b0, {TOTAL_W{1'b1}}} : (((TOTAL_W + 1)'(1)) << COUNT_BITS) - (TOTAL_W + 1)'(1);

	localparam logic [7:0] CR_BYTE = 8'h0D;

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_DATA = 2'd1,
		PH_OVER = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EARLY    = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.hit   = 1'b1;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.value = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.value = 4'(c - 8'h57);
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

[src/cblc_if.sv]
// ----------------------------------------------------------------------------
// cblc_in_if / cblc_out_if
// Valid/ready channels for body bytes in and length results out.
// ----------------------------------------------------------------------------
interface cblc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       end_of_body;

	modport source (output valid, output body_byte, output end_of_body, input ready);
	modport sink   (input valid, input body_byte, input end_of_body, output ready);
endinterface

interface cblc_out_if;
	logic                         valid;
	logic                         ready;
	logic [cblc_pkg::TOTAL_W-1:0] total_length;
	logic [1:0]                   status;

	modport source (output valid, output total_length, output status, input ready);
	modport sink   (input valid, input total_length, input status, output ready);
endinterface

[src/chunked_body_length_checker_top.sv]
// ----------------------------------------------------------------------------
// chunked_body_length_checker_top
// Parses chunk-size lines of a chunked body, checks data line lengths,
// and reports the saturating total of chunk sizes or an error code.
//
//   channel  dir  word                         per word
//   body     in   body_byte, end_of_body       one body byte
//   result   out  total_length, status         at most one per body byte
//
// One body byte is taken per cycle while body.ready is high; its result goes
// to the output register, or to a skid register behind it while the output
// register holds an unread result, so input stalls only while both are full.
// arst_n clears the parser state and empties both result registers.
// ----------------------------------------------------------------------------
module chunked_body_length_checker_top (
	input logic           clk,
	input logic           arst_n,
	cblc_in_if.sink       body,
	cblc_out_if.source    result
);

	cblc_pkg::phase_t                 phase_q, phase_n;
	logic [cblc_pkg::CHUNK_W-1:0]     chunk_q, chunk_n;
	logic [cblc_pkg::REM_W-1:0]       rem_q, rem_n;
	logic [cblc_pkg::TOTAL_W-1:0]     total_q, total_n;
	logic                             acr_q, acr_n;
	logic [cblc_pkg::DIGIT_W-1:0]     dig_q, dig_n;

	logic                             emit;
	cblc_pkg::status_t                status;
	logic                             add_en;
	logic [cblc_pkg::TOTAL_W:0]       sum;
	cblc_pkg::hex_t                   hex;
	logic                             accept;
	logic                             pop;

	logic                             out_v_q, skid_v_q;
	logic [cblc_pkg::TOTAL_W-1:0]     out_tot_q, skid_tot_q;
	cblc_pkg::status_t                out_st_q, skid_st_q;

	assign accept = body.valid && body.ready;
	assign pop    = out_v_q && result.ready;
	assign hex    = cblc_pkg::hex_decode(body.body_byte);

	always_comb begin
		phase_n = phase_q;
		chunk_n = chunk_q;
		rem_n   = rem_q;
		acr_n   = acr_q;
		dig_n   = dig_q;
		emit    = 1'b0;
		status  = cblc_pkg::ST_OK;
		add_en  = 1'b0;
		case (phase_q)
			cblc_pkg::PH_SIZE: begin
				if (acr_q) begin
					acr_n   = 1'b0;
					rem_n   = cblc_pkg::REM_W'(chunk_q) + cblc_pkg::REM_W'(2);
					phase_n = cblc_pkg::PH_DATA;
				end else if (body.body_byte == cblc_pkg::CR_BYTE) begin
					add_en = 1'b1;
					if (chunk_q == '0) begin
						emit    = 1'b1;
						status  = cblc_pkg::ST_OK;
						phase_n = cblc_pkg::PH_DONE;
					end else begin
						acr_n = 1'b1;
					end
				end else if (hex.hit) begin
					if (dig_q >= cblc_pkg::DIGIT_W'(cblc_pkg::MAX_DIGITS)) begin
						emit    = 1'b1;
						status  = cblc_pkg::ST_TOO_LONG;
						phase_n = cblc_pkg::PH_DONE;
					end else begin
						chunk_n = {chunk_q[cblc_pkg::CHUNK_W-5:0], hex.value};
						dig_n   = dig_q + cblc_pkg::DIGIT_W'(1);
					end
				end
			end
			cblc_pkg::PH_DATA, cblc_pkg::PH_OVER: begin
				if (rem_q == '0) begin
					phase_n = cblc_pkg::PH_OVER;
				end else begin
					rem_n = rem_q - cblc_pkg::REM_W'(1);
				end
				if (acr_q) begin
					acr_n = 1'b0;
					if (phase_n == cblc_pkg::PH_OVER) begin
						emit    = 1'b1;
						status  = cblc_pkg::ST_MISMATCH;
						phase_n = cblc_pkg::PH_DONE;
					end else if (rem_n == '0) begin
						phase_n = cblc_pkg::PH_SIZE;
						chunk_n = '0;
						dig_n   = '0;
					end
				end else if (body.body_byte == cblc_pkg::CR_BYTE) begin
					acr_n = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (body.end_of_body && phase_n != cblc_pkg::PH_DONE) begin
			emit   = 1'b1;
			status = cblc_pkg::ST_EARLY;
			if (phase_n == cblc_pkg::PH_SIZE) begin
				if (!acr_n) begin
					add_en = 1'b1;
				end
				status = (chunk_n == '0) ? cblc_pkg::ST_OK : cblc_pkg::ST_EARLY;
			end
		end

		sum = {1'b0, total_q} + (cblc_pkg::TOTAL_W + 1)'(chunk_n);
		if (sum > cblc_pkg::TOTAL_CAP) begin
			sum = cblc_pkg::TOTAL_CAP;
		end
		total_n = add_en ? sum[cblc_pkg::TOTAL_W-1:0] : total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cblc_pkg::PH_SIZE;
			chunk_q <= '0;
			rem_q   <= '0;
			total_q <= '0;
			acr_q   <= 1'b0;
			dig_q   <= '0;
		end else if (accept) begin
			if (body.end_of_body) begin
				phase_q <= cblc_pkg::PH_SIZE;
				chunk_q <= '0;
				rem_q   <= '0;
				total_q <= '0;
				acr_q   <= 1'b0;
				dig_q   <= '0;
			end else begin
				phase_q <= phase_n;
				chunk_q <= chunk_n;
				rem_q   <= rem_n;
				total_q <= total_n;
				acr_q   <= acr_n;
				dig_q   <= dig_n;
			end
		end
	end

	// hold results in the output register, overflow into the skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (accept && emit) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_tot_q <= skid_tot_q;
				out_st_q  <= skid_st_q;
			end
		end else if (accept && emit) begin
			if (out_v_q && !pop) begin
				skid_tot_q <= total_n;
				skid_st_q  <= status;
			end else begin
				out_tot_q <= total_n;
				out_st_q  <= status;
			end
		end
	end

	assign body.ready          = !skid_v_q;
	assign result.valid        = out_v_q;
	assign result.total_length = out_tot_q;
	assign result.status       = out_st_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && body.end_of_body) |=> (phase_q == cblc_pkg::PH_SIZE && total_q == '0))
		else $error("end of body did not restart the parser");

	a_rem_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != cblc_pkg::PH_DATA) |-> (rem_q == '0))
		else $error("byte count left over outside data phase");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, total_q} <= cblc_pkg::TOTAL_CAP))
		else $error("running total above saturation limit");

endmodule

[tb/sv/tb_chunked_body_length_checker_top.sv]
// ----------------------------------------------------------------------------
// tb_chunked_body_length_checker_top
// Feeds chunked bodies into the length checker one byte per word, predicts
// the total and status of every body and compares each result word with the
// oldest prediction. Directed bodies cover the corner cases, then random
// bodies follow: mostly well-formed chunk sequences, with truncated, overrun,
// over-long and saturating bodies and noise mixed in. Both sides idle at
// random, the receiver holds off once for a long stretch and the sender
// waits once or more until every result has come back.
// ----------------------------------------------------------------------------
module tb_chunked_body_length_checker_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] data;
		logic       eob;
		int         gap;
		logic       drain;
		logic       hold_mark;
	} body_word_t;

	typedef struct packed {
		logic [cblc_pkg::TOTAL_W-1:0] total;
		cblc_pkg::status_t            status;
	} length_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_eob = 1'b0;
	logic       out_ready = 1'b0;
	logic       hold_start = 1'b0;
	logic       rx_hold = 1'b0;

	body_word_t     body_words[$];
	body_word_t     next_word;
	length_result_t awaited_lengths[$];
	length_result_t got_length;

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	int  results_seen = 0;
	bit  tx_burst = 1'b0;
	bit  mark_drain = 1'b0;
	bit  mark_hold = 1'b0;

	cblc_pkg::phase_t             parse_phase = cblc_pkg::PH_SIZE;
	logic [cblc_pkg::CHUNK_W-1:0] size_acc = '0;
	logic [cblc_pkg::REM_W-1:0]   bytes_left = '0;
	logic [cblc_pkg::TOTAL_W-1:0] length_sum = '0;
	logic                         cr_seen = 1'b0;
	logic [cblc_pkg::DIGIT_W-1:0] digits = '0;
	logic                         result_given = 1'b0;

	cblc_in_if  body_ch();
	cblc_out_if result_ch();

	assign body_ch.valid       = in_valid;
	assign body_ch.body_byte   = in_byte;
	assign body_ch.end_of_body = in_eob;
	assign result_ch.ready     = out_ready;

	chunked_body_length_checker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_ch),
		.result (result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end else if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end else if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end
		return -1;
	endfunction

	function automatic void clear_parser();
		parse_phase  = cblc_pkg::PH_SIZE;
		size_acc     = '0;
		bytes_left   = '0;
		length_sum   = '0;
		cr_seen      = 1'b0;
		digits       = '0;
		result_given = 1'b0;
	endfunction

	function automatic void add_size_to_sum();
		logic [cblc_pkg::TOTAL_W:0] sum;
		sum = {1'b0, length_sum} + {1'b0, size_acc};
		length_sum = (sum > cblc_pkg::TOTAL_CAP) ?
			cblc_pkg::TOTAL_W'(cblc_pkg::TOTAL_CAP) : sum[cblc_pkg::TOTAL_W-1:0];
	endfunction

	function automatic void post_length(input cblc_pkg::status_t st);
		length_result_t r;
		r.total  = length_sum;
		r.status = st;
		awaited_lengths.push_back(r);
		result_given = 1'b1;
		parse_phase  = cblc_pkg::PH_DONE;
	endfunction

	function automatic void parse_body_byte(input logic [7:0] b, input logic eob);
		int                d;
		cblc_pkg::status_t st;
		d = hex_value(b);
		case (parse_phase)
			cblc_pkg::PH_SIZE: begin
				if (cr_seen) begin
					cr_seen     = 1'b0;
					bytes_left  = {2'b00, size_acc} + cblc_pkg::REM_W'(2);
					parse_phase = cblc_pkg::PH_DATA;
				end else if (b == cblc_pkg::CR_BYTE) begin
					add_size_to_sum();
					if (size_acc == '0) begin
						post_length(cblc_pkg::ST_OK);
					end else begin
						cr_seen = 1'b1;
					end
				end else if (d >= 0) begin
					if (digits >= cblc_pkg::MAX_DIGITS) begin
						post_length(cblc_pkg::ST_TOO_LONG);
					end else begin
						size_acc = {size_acc[cblc_pkg::CHUNK_W-5:0], 4'(d)};
						digits++;
					end
				end
			end
			cblc_pkg::PH_DATA, cblc_pkg::PH_OVER: begin
				if (bytes_left == '0) begin
					parse_phase = cblc_pkg::PH_OVER;
				end else begin
					bytes_left--;
				end
				if (cr_seen) begin
					cr_seen = 1'b0;
					if (parse_phase == cblc_pkg::PH_OVER) begin
						post_length(cblc_pkg::ST_MISMATCH);
					end else if (bytes_left == '0) begin
						parse_phase = cblc_pkg::PH_SIZE;
						size_acc    = '0;
						digits      = '0;
					end
				end else if (b == cblc_pkg::CR_BYTE) begin
					cr_seen = 1'b1;
				end
			end
			default: ;
		endcase
		if (eob) begin
			if (!result_given) begin
				st = cblc_pkg::ST_EARLY;
				if (parse_phase == cblc_pkg::PH_SIZE) begin
					if (!cr_seen) begin
						add_size_to_sum();
					end
					st = (size_acc == '0) ? cblc_pkg::ST_OK : cblc_pkg::ST_EARLY;
				end
				post_length(st);
			end
			clear_parser();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic push_word(input logic [7:0] b, input logic eob);
		body_word_t w;
		w.data      = b;
		w.eob       = eob;
		w.gap       = tx_burst ? 0 : $urandom_range(0, 6);
		w.drain     = mark_drain;
		w.hold_mark = mark_hold;
		mark_drain  = 1'b0;
		mark_hold   = 1'b0;
		body_words.push_back(w);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_word(s[i], 1'b0);
		end
	endtask

	task automatic close_body();
		body_word_t w;
		w = body_words.pop_back();
		w.eob = 1'b1;
		body_words.push_back(w);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'("0") + 8'(nib);
		end
		return (($urandom_range(0, 1) == 0) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
	endfunction

	function automatic logic [7:0] filler_char();
		string s;
		s = "; =_-xyzGHQ\t";
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] line_feed();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h0A;
	endfunction

	task automatic push_size_line(input logic [31:0] size);
		int n;
		int width;
		n = 1;
		while (n < cblc_pkg::MAX_DIGITS && (size >> (4 * n)) != 0) begin
			n++;
		end
		width = $urandom_range(n, cblc_pkg::MAX_DIGITS);
		if (size == 0 && $urandom_range(0, 3) == 0) begin
			width = 0;
		end
		if ($urandom_range(0, 4) == 0) begin
			push_word(filler_char(), 1'b0);
		end
		for (int i = width - 1; i >= 0; i--) begin
			push_word(hex_char(size[4 * i +: 4]), 1'b0);
		end
		if ($urandom_range(0, 3) == 0) begin
			push_word(";", 1'b0);
			repeat ($urandom_range(1, 3)) push_word(filler_char(), 1'b0);
		end
		push_word(cblc_pkg::CR_BYTE, 1'b0);
		push_word(line_feed(), 1'b0);
	endtask

	task automatic push_chunk_data(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (b == cblc_pkg::CR_BYTE && $urandom_range(0, 3) != 0) begin
				b = 8'h2E;
			end
			push_word(b, 1'b0);
		end
		push_word(cblc_pkg::CR_BYTE, 1'b0);
		push_word(line_feed(), 1'b0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			in_byte     <= 8'h00;
			in_eob      <= 1'b0;
			hold_start  <= 1'b0;
			idle_cycles = 0;
		end else begin
			if (in_valid && body_ch.ready) begin
				parse_body_byte(in_byte, in_eob);
			end
			if (!in_valid || body_ch.ready) begin
				if (body_words.size() != 0 && idle_cycles >= body_words[0].gap &&
				    !(body_words[0].drain && awaited_lengths.size() != 0)) begin
					next_word = body_words.pop_front();
					in_valid <= 1'b1;
					in_byte  <= next_word.data;
					in_eob   <= next_word.eob;
					if (next_word.hold_mark) begin
						hold_start <= 1'b1;
					end
					idle_cycles = 0;
				end else begin
					in_valid <= 1'b0;
					idle_cycles++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ready && result_ch.valid) begin
				if (awaited_lengths.size() == 0) begin
					report_mismatch($sformatf("unexpected result total %0h status %0d",
						result_ch.total_length, result_ch.status));
				end else begin
					got_length = awaited_lengths.pop_front();
					if (result_ch.total_length !== got_length.total) begin
						report_mismatch($sformatf("total_length got %0h want %0h",
							result_ch.total_length, got_length.total));
					end
					if (result_ch.status !== got_length.status) begin
						report_mismatch($sformatf("status got %0d want %0d",
							result_ch.status, got_length.status));
					end
				end
				results_seen++;
				stall_left = ((results_seen % 32) < 8) ? 0 : $urandom_range(0, 6);
			end else if (stall_left > 0) begin
				stall_left--;
			end else if ((results_seen % 32) >= 8 && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6);
			end
			out_ready <= !rx_hold && stall_left == 0;
		end
	end

	// hold the result side off while a run of short bodies backs up the input
	initial begin
		wait (hold_start);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (200) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int         kind;
		int         nchunks;
		int         size;
		int         start;
		int         keep;
		int         bodies;
		bit         hold_done;
		logic [31:0] big;

		bodies    = 0;
		hold_done = 1'b0;

		push_text("\r");
		push_word(8'h0A, 1'b1);
		push_word("0", 1'b1);
		push_text("aBcDeF09");
		push_word("1", 1'b1);
		push_text("1\r\n");
		push_word(8'h00, 1'b0);
		push_word(cblc_pkg::CR_BYTE, 1'b0);
		push_word(8'h80, 1'b1);
		push_text("1\r\nab\r");
		push_word(8'hFF, 1'b1);

		while (body_words.size() < 1124) begin
			bodies++;
			tx_burst   = ($urandom_range(0, 3) == 0);
			mark_drain = (bodies % 15 == 0);
			if (!hold_done && body_words.size() > 500) begin
				hold_done = 1'b1;
				tx_burst  = 1'b1;
				mark_hold = 1'b1;
				repeat (40) begin
					push_word("0", 1'b0);
					push_word(cblc_pkg::CR_BYTE, 1'b0);
					push_word(8'h0A, 1'b1);
				end
				tx_burst = 1'b0;
			end
			start   = body_words.size();
			kind    = $urandom_range(0, 9);
			nchunks = $urandom_range((kind == 9) ? 1 : 0, 3);
			repeat (nchunks) begin
				size = $urandom_range(1, 12);
				push_size_line(size);
				push_chunk_data(size);
			end
			case (kind)
				4: begin
					repeat ($urandom_range(1, 12)) push_word(8'($urandom), 1'b0);
					close_body();
				end
				7: begin
					size = $urandom_range(1, 8);
					push_size_line(size);
					push_chunk_data(size + $urandom_range(1, 3));
					push_word(8'($urandom), 1'b1);
				end
				8: begin
					repeat ($urandom_range(9, 11)) push_word(hex_char(4'($urandom)), 1'b0);
					repeat ($urandom_range(0, 2)) push_word(8'($urandom), 1'b0);
					push_word(8'($urandom), 1'b1);
				end
				9: begin
					big = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
					for (int i = cblc_pkg::MAX_DIGITS - 1; i >= 0; i--) begin
						push_word(hex_char(big[4 * i +: 4]), 1'b0);
					end
					if ($urandom_range(0, 1) == 0) begin
						push_word(cblc_pkg::CR_BYTE, 1'b0);
					end
					close_body();
				end
				default: begin
					if (kind == 5 && nchunks > 0) begin
						close_body();
					end else begin
						push_size_line(0);
						repeat ($urandom_range(0, 2)) push_word(8'($urandom), 1'b0);
						push_word(8'($urandom), 1'b1);
						if (kind == 6) begin
							keep = $urandom_range(1, body_words.size() - start);
							while (body_words.size() > start + keep) begin
								void'(body_words.pop_back());
							end
							close_body();
						end
					end
				end
			endcase
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (body_words.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (awaited_lengths.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
